[rtl/core/skmj_pkg.sv]
package skmj_pkg;

  localparam int unsigned IDX_W = 10;

  typedef enum logic [1:0] {
    OP_LOAD_END   = 2'd0,
    OP_LOAD_START = 2'd1,
    OP_READ_BASE  = 2'd2,
    OP_CLEAR      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_VERDICT = 2'd3
  } status_e;

  // table command: lookup, insert at probe slot, mark found entry dup, clear sweep
  typedef struct packed {
    logic look;
    logic ins;
    logic mark;
    logic clr;
  } tab_cmd_t;

  typedef struct packed {
    logic busy;
    logic hit;
    logic dup;
  } tab_sts_t;

endpackage

[rtl/core/split_kmer_junction_matcher.sv]
// Load: a hash lookup in the selected table, then an insert or a dup mark. A read
// base with a full window probes both tables in parallel, forward then reverse,
// each phase waiting for the slower table. A last base ends with the verdict beat.
// A clear sweeps 2*TABLE_DEPTH hash entries, one per cycle, with the input stalled.
// Reset (rst_ni low, async) empties the read window and starts the same sweep;
// results wait in an output register.
module split_kmer_junction_matcher #(
  parameter int unsigned FLANK_BASES = 30,
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [2*FLANK_BASES-1:0]     flank_key_i,
  input  logic [2:0]                   base_code_i,
  input  logic                         last_base_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [skmj_pkg::IDX_W-1:0]   entry_index_o,
  output logic                         matched_o,
  output logic                         reverse_strand_o,
  output logic [skmj_pkg::IDX_W-1:0]   end_index_o,
  output logic [skmj_pkg::IDX_W-1:0]   start_index_o
);

  localparam int unsigned KW = 2 * FLANK_BASES;
  localparam int unsigned SW = $clog2(TABLE_DEPTH);
  localparam int unsigned FW = SW + 1;
  localparam int unsigned RW = $clog2(KW + 1);
  localparam int unsigned IW = skmj_pkg::IDX_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CLR  = 6'b000010,
    S_LOAD = 6'b000100,
    S_FWD  = 6'b001000,
    S_REV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  function automatic logic [KW-1:0] rc_f(input logic [KW-1:0] k);
    logic [KW-1:0] c;
    logic [KW-1:0] r;
    c = ~k;
    for (int i = 0; i < FLANK_BASES; i++) begin
      r[2*i +: 2] = c[KW-2-2*i +: 2];
    end
    return r;
  endfunction

  state_e        state_q;
  logic [KW-1:0] older_q, newer_q, older_d, newer_d;
  logic [RW-1:0] run_q, run_d;
  logic          clean;
  logic          fwd_v_q, rev_v_q;
  logic [SW-1:0] fwd_e_q, fwd_s_q, rev_e_q, rev_s_q;
  logic [FW-1:0] end_fill_q, start_fill_q;
  logic          last_q, sel_q;
  logic [1:0]    pend_status_q;
  logic [IW-1:0] pend_idx_q;
  logic          fin_verdict;

  skmj_pkg::tab_cmd_t e_cmd, s_cmd;
  skmj_pkg::tab_sts_t e_sts, s_sts;
  logic [KW-1:0]      e_key, s_key;
  logic [SW-1:0]      ins_slot, e_slot, s_slot;

  logic in_fire, out_free, busy_any, e_ok, s_ok;
  logic sel_hit, sel_dup, sel_full;
  logic [SW-1:0] sel_slot;
  logic [FW-1:0] sel_fill;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_o || out_ready_i;
  assign busy_any = e_sts.busy || s_sts.busy;
  assign e_ok     = e_sts.hit && !e_sts.dup;
  assign s_ok     = s_sts.hit && !s_sts.dup;
  assign in_ready_o = (state_q == S_IDLE);
  assign fin_verdict = (pend_status_q == skmj_pkg::ST_VERDICT);

  assign clean   = !base_code_i[2];
  assign older_d = {older_q[KW-3:0], newer_q[KW-1 -: 2]};
  assign newer_d = {newer_q[KW-3:0], clean ? base_code_i[1:0] : 2'b00};
  always_comb begin
    run_d = '0;
    if (clean) begin
      run_d = (run_q < RW'(KW)) ? run_q + RW'(1) : run_q;
    end
  end

  assign sel_hit  = sel_q ? s_sts.hit : e_sts.hit;
  assign sel_dup  = sel_q ? s_sts.dup : e_sts.dup;
  assign sel_slot = sel_q ? s_slot : e_slot;
  assign sel_fill = sel_q ? start_fill_q : end_fill_q;
  assign sel_full = (sel_fill == FW'(TABLE_DEPTH));
  assign ins_slot = SW'(sel_fill);

  always_comb begin
    e_cmd = '0;
    s_cmd = '0;
    e_key = older_d;
    s_key = newer_d;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (skmj_pkg::op_e'(operation_i))
            skmj_pkg::OP_LOAD_END: begin
              e_cmd.look = 1'b1;
              e_key      = flank_key_i;
            end
            skmj_pkg::OP_LOAD_START: begin
              s_cmd.look = 1'b1;
              s_key      = flank_key_i;
            end
            skmj_pkg::OP_CLEAR: begin
              e_cmd.clr = 1'b1;
              s_cmd.clr = 1'b1;
            end
            default: begin
              e_cmd.look = clean && (run_d == RW'(KW));
              s_cmd.look = clean && (run_d == RW'(KW));
            end
          endcase
        end
      end
      S_LOAD: begin
        if (!busy_any && !sel_hit && !sel_full) begin
          e_cmd.ins = !sel_q;
          s_cmd.ins = sel_q;
        end else if (!busy_any && sel_hit) begin
          e_cmd.mark = !sel_q;
          s_cmd.mark = sel_q;
        end
      end
      S_FWD: begin
        e_key = rc_f(newer_q);
        s_key = rc_f(older_q);
        e_cmd.look = !busy_any;
        s_cmd.look = !busy_any;
      end
      default: ;
    endcase
  end

  skmj_table #(.FLANK_BASES(FLANK_BASES), .TABLE_DEPTH(TABLE_DEPTH)) u_end_tab (
    .clk_i, .rst_ni, .cmd_i(e_cmd), .key_i(e_key), .slot_i(ins_slot),
    .sts_o(e_sts), .slot_o(e_slot)
  );

  skmj_table #(.FLANK_BASES(FLANK_BASES), .TABLE_DEPTH(TABLE_DEPTH)) u_start_tab (
    .clk_i, .rst_ni, .cmd_i(s_cmd), .key_i(s_key), .slot_i(ins_slot),
    .sts_o(s_sts), .slot_o(s_slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      older_q       <= '0;
      newer_q       <= '0;
      run_q         <= '0;
      fwd_v_q       <= 1'b0;
      rev_v_q       <= 1'b0;
      end_fill_q    <= '0;
      start_fill_q  <= '0;
      last_q        <= 1'b0;
      sel_q         <= 1'b0;
      pend_status_q <= skmj_pkg::ST_ADDED;
      out_valid_o   <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && state_q != S_FIN) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (skmj_pkg::op_e'(operation_i))
              skmj_pkg::OP_LOAD_END: begin
                sel_q   <= 1'b0;
                state_q <= S_LOAD;
              end
              skmj_pkg::OP_LOAD_START: begin
                sel_q   <= 1'b1;
                state_q <= S_LOAD;
              end
              skmj_pkg::OP_CLEAR: begin
                older_q      <= '0;
                newer_q      <= '0;
                run_q        <= '0;
                fwd_v_q      <= 1'b0;
                rev_v_q      <= 1'b0;
                end_fill_q   <= '0;
                start_fill_q <= '0;
                state_q      <= S_CLR;
              end
              default: begin
                older_q       <= older_d;
                newer_q       <= newer_d;
                run_q         <= run_d;
                last_q        <= last_base_i;
                pend_status_q <= skmj_pkg::ST_VERDICT;
                if (clean && run_d == RW'(KW)) begin
                  state_q <= S_FWD;
                end else if (last_base_i) begin
                  state_q <= S_FIN;
                end
              end
            endcase
          end
        end
        S_CLR: begin
          if (!busy_any) begin
            state_q <= S_IDLE;
          end
        end
        S_LOAD: begin
          if (!busy_any) begin
            state_q <= S_FIN;
            if (sel_hit) begin
              pend_status_q <= skmj_pkg::ST_DUP;
            end else if (sel_full) begin
              pend_status_q <= skmj_pkg::ST_FULL;
            end else begin
              pend_status_q <= skmj_pkg::ST_ADDED;
              if (sel_q) begin
                start_fill_q <= start_fill_q + FW'(1);
              end else begin
                end_fill_q <= end_fill_q + FW'(1);
              end
            end
          end
        end
        S_FWD: begin
          if (!busy_any) begin
            if (!fwd_v_q && e_ok && s_ok) begin
              fwd_v_q <= 1'b1;
            end
            state_q <= S_REV;
          end
        end
        S_REV: begin
          if (!busy_any) begin
            if (e_ok && s_ok) begin
              rev_v_q <= 1'b1;
            end
            state_q <= last_q ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
            if (pend_status_q == skmj_pkg::ST_VERDICT) begin
              older_q <= '0;
              newer_q <= '0;
              run_q   <= '0;
              fwd_v_q <= 1'b0;
              rev_v_q <= 1'b0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && !busy_any) begin
      pend_idx_q <= sel_hit ? IW'(sel_slot) : (sel_full ? '0 : IW'(ins_slot));
    end
    if (state_q == S_FWD && !busy_any && !fwd_v_q) begin
      fwd_e_q <= e_slot;
      fwd_s_q <= s_slot;
    end
    if (state_q == S_REV && !busy_any && e_ok && s_ok) begin
      rev_e_q <= e_slot;
      rev_s_q <= s_slot;
    end
    if (state_q == S_FIN && out_free) begin
      status_o         <= pend_status_q;
      entry_index_o    <= fin_verdict ? '0 : pend_idx_q;
      matched_o        <= fin_verdict && (fwd_v_q || rev_v_q);
      reverse_strand_o <= fin_verdict && !fwd_v_q && rev_v_q;
      if (fin_verdict && fwd_v_q) begin
        end_index_o   <= IW'(fwd_e_q);
        start_index_o <= IW'(fwd_s_q);
      end else if (fin_verdict && rev_v_q) begin
        end_index_o   <= IW'(rev_e_q);
        start_index_o <= IW'(rev_s_q);
      end else begin
        end_index_o   <= '0;
        start_index_o <= '0;
      end
    end
  end

endmodule

[rtl/core/skmj_table.sv]
module skmj_table #(
  parameter int unsigned FLANK_BASES = 30,
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  skmj_pkg::tab_cmd_t             cmd_i,
  input  logic [2*FLANK_BASES-1:0]       key_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] slot_i,
  output skmj_pkg::tab_sts_t             sts_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot_o
);

  localparam int unsigned KW = 2 * FLANK_BASES;
  localparam int unsigned SW = $clog2(TABLE_DEPTH);
  localparam int unsigned HW = SW + 1;
  localparam int unsigned EW = 2 + SW + KW;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_RD   = 4'b0010,
    T_CMP  = 4'b0100,
    T_CLR  = 4'b1000
  } tstate_e;

  function automatic logic [HW-1:0] hash_f(input logic [KW-1:0] k);
    logic [HW-1:0] h;
    h = '0;
    for (int j = 0; j < KW; j++) begin
      h[j % HW] = h[j % HW] ^ k[j];
    end
    return h;
  endfunction

  tstate_e       state_q;
  logic [HW-1:0] cnt_q;
  logic [HW-1:0] addr_q;
  logic [KW-1:0] key_q;
  logic          hit_q, dup_q;
  logic [SW-1:0] slot_q;
  logic [EW-1:0] mem [1 << HW];
  logic [EW-1:0] rdata_q;

  logic          r_used, r_dup;
  logic [SW-1:0] r_slot;
  logic [KW-1:0] r_key;

  assign {r_used, r_dup, r_slot, r_key} = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_CLR;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        T_IDLE: begin
          if (cmd_i.clr) begin
            cnt_q   <= '0;
            state_q <= T_CLR;
          end else if (cmd_i.look) begin
            state_q <= T_RD;
          end
        end
        T_RD:  state_q <= T_CMP;
        T_CMP: begin
          if (!r_used || r_key == key_q) begin
            state_q <= T_IDLE;
          end else begin
            state_q <= T_RD;
          end
        end
        T_CLR: begin
          cnt_q <= cnt_q + HW'(1);
          if (cnt_q == {HW{1'b1}}) begin
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_IDLE && cmd_i.look) begin
      key_q  <= key_i;
      addr_q <= hash_f(key_i);
    end else if (state_q == T_CMP) begin
      if (!r_used) begin
        hit_q <= 1'b0;
      end else if (r_key == key_q) begin
        hit_q  <= 1'b1;
        dup_q  <= r_dup;
        slot_q <= r_slot;
      end else begin
        addr_q <= addr_q + HW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_CLR) begin
      mem[cnt_q] <= '0;
    end else if (state_q == T_IDLE && cmd_i.ins) begin
      mem[addr_q] <= {1'b1, 1'b0, slot_i, key_q};
    end else if (state_q == T_IDLE && cmd_i.mark) begin
      mem[addr_q] <= {1'b1, 1'b1, slot_q, key_q};
    end
    rdata_q <= mem[addr_q];
  end

  assign sts_o.busy = (state_q != T_IDLE);
  assign sts_o.hit  = hit_q;
  assign sts_o.dup  = dup_q;
  assign slot_o     = slot_q;

endmodule

[rtl/core/skmj_checker.sv]
module skmj_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] operation_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic       matched_o,
  input logic       reverse_strand_o,
  input logic [9:0] end_index_o,
  input logic [9:0] start_index_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result beat dropped while stalled");

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == skmj_pkg::OP_CLEAR |=> !in_ready_o)
    else $error("input taken during clear sweep");

  a_load_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != skmj_pkg::ST_VERDICT |->
      !matched_o && !reverse_strand_o && end_index_o == '0 && start_index_o == '0)
    else $error("load beat carries verdict fields");

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |-> !reverse_strand_o && end_index_o == '0)
    else $error("unmatched verdict with indices");

endmodule

bind split_kmer_junction_matcher skmj_checker u_skmj_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .operation_i(operation_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .status_o(status_o), .matched_o(matched_o), .reverse_strand_o(reverse_strand_o),
  .end_index_o(end_index_o), .start_index_o(start_index_o)
);

[dv/tb_split_kmer_junction_matcher.sv]
`timescale 1ns / 1ps

module tb_split_kmer_junction_matcher;

  localparam int KB = 30;
  localparam int KW = 2 * KB;
  localparam int DEPTH = 1024;
  localparam int ITEMS = 800;
  localparam int STALL_LIMIT = 20000;
  localparam int QUIET_TAIL = 150;

  typedef struct {
    skmj_pkg::op_e   op;
    logic [KW-1:0]   key;
    logic [2:0]      base;
    logic            last;
  } beat_t;

  typedef struct packed {
    logic [1:0]                 st;
    logic [skmj_pkg::IDX_W-1:0] ent;
    logic                       m;
    logic                       r;
    logic [skmj_pkg::IDX_W-1:0] ei;
    logic [skmj_pkg::IDX_W-1:0] si;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [1:0]      operation = '0;
  logic [KW-1:0]   flank_key = '0;
  logic [2:0]      base_code = '0;
  logic            last_base = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [1:0]      status;
  logic [skmj_pkg::IDX_W-1:0] entry_index, end_index, start_index;
  logic            matched, reverse_strand;

  split_kmer_junction_matcher dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .flank_key_i      (flank_key),
    .base_code_i      (base_code),
    .last_base_i      (last_base),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .entry_index_o    (entry_index),
    .matched_o        (matched),
    .reverse_strand_o (reverse_strand),
    .end_index_o      (end_index),
    .start_index_o    (start_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  beat_t    pending_beats[$];
  verdict_t expected_verdicts[$];
  int       errors = 0;

  // junction predictor state: table 0 holds exon ends, table 1 exon starts
  logic [KW-1:0] tab_key[2][DEPTH];
  bit            tab_vld[2][DEPTH];
  bit            tab_dup[2][DEPTH];
  int            tab_fill[2];
  logic [KW-1:0] win_old, win_new;
  int            clean_cnt;
  bit            fwd_hit, rev_hit;
  int            fwd_e, fwd_s, rev_e, rev_s;

  logic [KW-1:0] end_pool[$], start_pool[$];

  function automatic void queue_beat(beat_t b);
    pending_beats = {pending_beats, b};
  endfunction

  function automatic void queue_verdict(verdict_t v);
    expected_verdicts = {expected_verdicts, v};
  endfunction

  function automatic int find_slot(int t, logic [KW-1:0] k);
    for (int i = 0; i < tab_fill[t]; i++)
      if (tab_vld[t][i] && tab_key[t][i] == k) return i;
    return -1;
  endfunction

  function automatic int unique_slot(int t, logic [KW-1:0] k);
    int s;
    s = find_slot(t, k);
    if (s >= 0 && tab_dup[t][s]) return -1;
    return s;
  endfunction

  function automatic logic [KW-1:0] rc_key(logic [KW-1:0] k);
    logic [KW-1:0] c, r;
    c = ~k;
    r = '0;
    for (int i = 0; i < KB; i++) begin
      r = {r[KW-3:0], c[1:0]};
      c = c >> 2;
    end
    return r;
  endfunction

  function automatic void drop_read();
    win_old = '0;
    win_new = '0;
    clean_cnt = 0;
    fwd_hit = 0;
    rev_hit = 0;
    fwd_e = 0; fwd_s = 0; rev_e = 0; rev_s = 0;
  endfunction

  function automatic void wipe_tables();
    for (int t = 0; t < 2; t++) begin
      tab_fill[t] = 0;
      for (int i = 0; i < DEPTH; i++) begin
        tab_vld[t][i] = 0;
        tab_dup[t][i] = 0;
      end
    end
  endfunction

  function automatic void predict_junction(beat_t b);
    verdict_t v;
    int t, s, e;
    bit clean;
    v = '0;
    case (b.op)
      skmj_pkg::OP_LOAD_END, skmj_pkg::OP_LOAD_START: begin
        t = (b.op == skmj_pkg::OP_LOAD_END) ? 0 : 1;
        s = find_slot(t, b.key);
        if (s >= 0) begin
          tab_dup[t][s] = 1;
          v.st = skmj_pkg::ST_DUP;
          v.ent = s[skmj_pkg::IDX_W-1:0];
        end else if (tab_fill[t] >= DEPTH) begin
          v.st = skmj_pkg::ST_FULL;
        end else begin
          s = tab_fill[t];
          tab_key[t][s] = b.key;
          tab_vld[t][s] = 1;
          tab_dup[t][s] = 0;
          v.st = skmj_pkg::ST_ADDED;
          v.ent = s[skmj_pkg::IDX_W-1:0];
          tab_fill[t]++;
        end
        queue_verdict(v);
      end
      skmj_pkg::OP_CLEAR: begin
        wipe_tables();
        drop_read();
      end
      default: begin
        clean = (b.base <= 3'd3);
        win_old = {win_old[KW-3:0], win_new[KW-1:KW-2]};
        win_new = {win_new[KW-3:0], clean ? b.base[1:0] : 2'd0};
        if (!clean) begin
          clean_cnt = 0;
        end else begin
          if (clean_cnt < KW) clean_cnt++;
          if (clean_cnt >= KW) begin
            if (!fwd_hit) begin
              e = unique_slot(0, win_old);
              s = unique_slot(1, win_new);
              if (e >= 0 && s >= 0) begin
                fwd_hit = 1; fwd_e = e; fwd_s = s;
              end
            end
            e = unique_slot(0, rc_key(win_new));
            s = unique_slot(1, rc_key(win_old));
            if (e >= 0 && s >= 0) begin
              rev_hit = 1; rev_e = e; rev_s = s;
            end
          end
        end
        if (b.last) begin
          v.st = skmj_pkg::ST_VERDICT;
          if (fwd_hit) begin
            v.m = 1;
            v.ei = fwd_e[skmj_pkg::IDX_W-1:0];
            v.si = fwd_s[skmj_pkg::IDX_W-1:0];
          end else if (rev_hit) begin
            v.m = 1; v.r = 1;
            v.ei = rev_e[skmj_pkg::IDX_W-1:0];
            v.si = rev_s[skmj_pkg::IDX_W-1:0];
          end
          queue_verdict(v);
          drop_read();
        end
      end
    endcase
  endfunction

  function automatic logic [KW-1:0] rand_key();
    return KW'({$urandom(), $urandom()} >> 4);
  endfunction

  // ---- stimulus builders
  task automatic add_load(skmj_pkg::op_e op, logic [KW-1:0] k);
    beat_t b;
    b.op = op; b.key = k; b.base = 3'($urandom); b.last = 1'($urandom);
    queue_beat(b);
    if (op == skmj_pkg::OP_LOAD_END) end_pool = {end_pool, k};
    else start_pool = {start_pool, k};
  endtask

  task automatic add_clear();
    beat_t b;
    b.op = skmj_pkg::OP_CLEAR; b.key = rand_key(); b.base = 3'($urandom);
    b.last = 1'($urandom);
    queue_beat(b);
  endtask

  task automatic add_base(logic [2:0] c, logic fin);
    beat_t b;
    b.op = skmj_pkg::OP_READ_BASE; b.key = rand_key(); b.base = c; b.last = fin;
    queue_beat(b);
  endtask

  task automatic add_flank(logic [KW-1:0] k);
    for (int i = KB - 1; i >= 0; i--) add_base({1'b0, k[2*i +: 2]}, 1'b0);
  endtask

  task automatic add_clean_bases(int n);
    for (int i = 0; i < n; i++) add_base(3'($urandom_range(0, 3)), 1'b0);
  endtask

  // noisy prefix, then the two flanks, then a random tail and the final base
  task automatic add_junction_read(logic [KW-1:0] k1, logic [KW-1:0] k2);
    int n;
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++)
      add_base(($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, 7))
                                           : 3'($urandom_range(0, 3)), 1'b0);
    add_flank(k1);
    add_flank(k2);
    add_clean_bases($urandom_range(0, 5));
    add_base(3'($urandom_range(0, 3)), 1'b1);
  endtask

  task automatic add_noise_read(int len);
    for (int i = 0; i < len - 1; i++)
      add_base(($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                           : 3'($urandom_range(0, 3)), 1'b0);
    add_base(3'($urandom_range(0, 7)), 1'b1);
  endtask

  function automatic logic [KW-1:0] pick(ref logic [KW-1:0] pool[$]);
    if (pool.size() == 0) return rand_key();
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  // ---- driver
  int  in_gap = 0;
  int  out_gap = 0;
  bit  quiet = 0;

  always @(posedge clk or negedge rst_n) begin
    beat_t b;
    bit    take;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) predict_junction(pending_beats.pop_front());
      quiet = (pending_beats.size() < QUIET_TAIL);
      if (!in_valid || in_ready) begin
        take = 0;
        if (in_gap > 0) in_gap--;
        else if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(0, 15);
        else if (pending_beats.size() > 0) take = 1;
        if (take) begin
          b = pending_beats[0];
          operation <= b.op;
          flank_key <= b.key;
          base_code <= b.base;
          last_base <= b.last;
        end
        in_valid <= take;
      end
    end
  end

  // ---- monitor and watchdog
  int stall_cnt = 0;

  always @(posedge clk or negedge rst_n) begin
    verdict_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
      stall_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {status, entry_index, matched, reverse_strand, end_index, start_index};
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected beat st=%0d ent=%0d m=%0d r=%0d e=%0d s=%0d", $realtime,
                   got.st, got.ent, got.m, got.r, got.ei, got.si);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp st=%0d ent=%0d m=%0d r=%0d e=%0d s=%0d", $realtime,
                     want.st, want.ent, want.m, want.r, want.ei, want.si);
            $display("%0t:          got st=%0d ent=%0d m=%0d r=%0d e=%0d s=%0d", $realtime,
                     got.st, got.ent, got.m, got.r, got.ei, got.si);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (pending_beats.size() == 0 && !in_valid && expected_verdicts.size() == 0))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb_split_kmer_junction_matcher: FAIL");
        $finish;
      end
    end
  end

  // ---- stimulus
  initial begin
    logic [KW-1:0] ka, kb, kc, kd;
    int sel;
    wipe_tables();
    drop_read();

    ka = rand_key(); kb = rand_key(); kc = rand_key(); kd = rand_key();
    add_load(skmj_pkg::OP_LOAD_END, '0);
    add_load(skmj_pkg::OP_LOAD_START, '1);
    add_load(skmj_pkg::OP_LOAD_END, ka);
    add_load(skmj_pkg::OP_LOAD_START, kb);
    add_load(skmj_pkg::OP_LOAD_END, ka);             // duplicate, ka now non-unique
    add_load(skmj_pkg::OP_LOAD_END, kc);
    add_load(skmj_pkg::OP_LOAD_START, kd);
    add_junction_read('0, '1);             // forward hit
    add_junction_read(ka, kb);             // blocked by duplicate
    add_junction_read(rc_key(kd), rc_key(kc)); // reverse hit
    add_base(3'd4, 1'b1);                  // single non-ACGT base read
    add_noise_read(20);                    // short read
    add_clean_bases(10);
    add_clear();                           // abandons read in progress
    add_junction_read(kc, kd);             // tables empty: no match

    // duplicate start key blocks an otherwise known pair
    add_load(skmj_pkg::OP_LOAD_END, kc);
    add_load(skmj_pkg::OP_LOAD_START, kb);
    add_load(skmj_pkg::OP_LOAD_START, kb);
    add_junction_read(kc, kb);
    add_clear();
    end_pool.delete();
    start_pool.delete();

    while (pending_beats.size() < ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        add_load(($urandom_range(0, 1) == 0) ? skmj_pkg::OP_LOAD_END
                                             : skmj_pkg::OP_LOAD_START,
                 ($urandom_range(0, 4) == 0) ? pick(end_pool) : rand_key());
      end else if (sel < 60) begin
        add_junction_read(pick(end_pool), pick(start_pool));
      end else if (sel < 80) begin
        add_junction_read(rc_key(pick(start_pool)), rc_key(pick(end_pool)));
      end else if (sel < 98) begin
        add_noise_read($urandom_range(1, 70));
      end else begin
        add_clear();
        end_pool.delete();
        start_pool.delete();
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_beats.size() == 0 && !in_valid && expected_verdicts.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_verdicts.size() == 0)
      $display("tb_split_kmer_junction_matcher: PASS");
    else
      $display("tb_split_kmer_junction_matcher: FAIL");
    $finish;
  end

endmodule
